FILE: src/clnw_pkg.sv
`default_nettype none
package clnw_pkg;

	// input command codes
	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_CHAR  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_STROBE_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_COMMAND_SETTLE = 2'd1;
	localparam logic [1:0] CFG_DATA_SETTLE    = 2'd2;

	localparam int unsigned US_W = 20;

	localparam logic [US_W-1:0] STROBE_WIDTH_RST   = 20'd100;
	localparam logic [US_W-1:0] COMMAND_SETTLE_RST = 20'd200000;
	localparam logic [US_W-1:0] DATA_SETTLE_RST    = 20'd100;

	// LCD command bytes
	localparam logic [7:0] LCD_WAKE_A     = 8'b0011_0011;
	localparam logic [7:0] LCD_WAKE_B     = 8'b0011_0010;
	localparam logic [7:0] LCD_FUNC_SET   = 8'b0010_1000;
	localparam logic [7:0] LCD_DISPLAY_ON = 8'b0000_1100;
	localparam logic [7:0] LCD_ENTRY_MODE = 8'b0000_0100;
	localparam logic [7:0] LCD_ERASE      = 8'b0000_0001;
	localparam logic [7:0] LCD_HOME       = 8'b0000_0010;
	localparam logic [7:0] LCD_SET_DDRAM  = 8'b1000_0000;

	localparam logic [7:0] ROW_BASE_0 = 8'h00;
	localparam logic [7:0] ROW_BASE_1 = 8'h40;
	localparam logic [7:0] ROW_BASE_2 = 8'h14;
	localparam logic [7:0] ROW_BASE_3 = 8'h54;

	typedef enum logic [1:0] {
		JOB_INIT,
		JOB_CLEAR,
		JOB_CHAR
	} job_kind_t;

	// one classified transaction, as queued between front and back
	typedef struct packed {
		job_kind_t  kind;
		logic       need_addr;
		logic [7:0] addr;
		logic [7:0] char_code;
	} job_t;

	typedef struct packed {
		logic [US_W-1:0] strobe_width;
		logic [US_W-1:0] command_settle;
		logic [US_W-1:0] data_settle;
	} cfg_t;

	function automatic logic [7:0] row_base(input logic [1:0] line);
		logic [7:0] b;
		unique case (line)
			2'd0:    b = ROW_BASE_0;
			2'd1:    b = ROW_BASE_1;
			2'd2:    b = ROW_BASE_2;
			default: b = ROW_BASE_3;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = LCD_WAKE_A;
			3'd1:    b = LCD_WAKE_B;
			3'd2:    b = LCD_FUNC_SET;
			3'd3:    b = LCD_DISPLAY_ON;
			default: b = LCD_ENTRY_MODE;
		endcase
		return b;
	endfunction

	// number of nibble strobes a job produces
	function automatic logic [3:0] job_nibbles(input job_t j);
		logic [3:0] n;
		unique case (j.kind)
			JOB_INIT:  n = 4'd10;
			JOB_CLEAR: n = 4'd4;
			JOB_CHAR:  n = j.need_addr ? 4'd4 : 4'd2;
			default:   n = 4'd2;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] job_byte(input job_t j, input logic [2:0] bidx);
		logic [7:0] b;
		unique case (j.kind)
			JOB_INIT:  b = init_byte(bidx);
			JOB_CLEAR: b = (bidx == 3'd0) ? LCD_ERASE : LCD_HOME;
			JOB_CHAR:  b = (j.need_addr && bidx == 3'd0) ? j.addr : j.char_code;
			default:   b = j.char_code;
		endcase
		return b;
	endfunction

	// register select: only the character byte itself is data
	function automatic logic job_rs(input job_t j, input logic [2:0] bidx);
		return (j.kind == JOB_CHAR) && !(j.need_addr && bidx == 3'd0);
	endfunction

endpackage
`default_nettype wire

FILE: src/clnw_cmd_if.sv
`default_nettype none
interface clnw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] char_code;
	logic       first_of_message;

	modport source (output valid, output command, output char_code,
		output first_of_message, input ready);
	modport sink (input valid, input command, input char_code,
		input first_of_message, output ready);
endinterface
`default_nettype wire

FILE: src/clnw_strobe_if.sv
`default_nettype none
interface clnw_strobe_if;
	logic        valid;
	logic        ready;
	logic        register_select;
	logic [3:0]  nibble;
	logic [19:0] pulse_us;
	logic [19:0] wait_after_us;
	logic        last;

	modport source (output valid, output register_select, output nibble,
		output pulse_us, output wait_after_us, output last, input ready);
	modport sink (input valid, input register_select, input nibble,
		input pulse_us, input wait_after_us, input last, output ready);
endinterface
`default_nettype wire

FILE: src/clnw_front.sv
`default_nettype none
module clnw_front #(
	parameter int unsigned CHARS_PER_LINE = 20,
	parameter int unsigned LINE_COUNT     = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	clnw_cmd_if.sink           cmd_ch,
	input  wire logic          q_full,
	output clnw_pkg::job_t     push_job,
	output logic               push
);
	localparam int unsigned COL_W  = $clog2(CHARS_PER_LINE);
	localparam int unsigned LINE_W = $clog2(LINE_COUNT + 1);

	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] line_q;
	logic [COL_W-1:0]  eff_col;
	logic [LINE_W-1:0] eff_line;
	logic [2:0]        line3;
	logic              accept;
	logic              is_char;
	logic              full_disp;
	logic              col_wrap;

	assign cmd_ch.ready = !q_full;
	assign accept       = cmd_ch.valid && !q_full;
	assign is_char      = cmd_ch.command == clnw_pkg::CMD_CHAR;

	// first character of a message restarts at line 0, column 0
	assign eff_col   = cmd_ch.first_of_message ? '0 : col_q;
	assign eff_line  = cmd_ch.first_of_message ? '0 : line_q;
	assign full_disp = eff_line == LINE_W'(LINE_COUNT);
	assign col_wrap  = eff_col == COL_W'(CHARS_PER_LINE - 1);
	assign line3     = 3'(eff_line);

	always_comb begin
		push_job.kind      = clnw_pkg::JOB_CHAR;
		push_job.need_addr = eff_col == '0;
		push_job.addr      = clnw_pkg::LCD_SET_DDRAM + clnw_pkg::row_base(line3[1:0]);
		push_job.char_code = cmd_ch.char_code;
		push               = 1'b0;
		unique case (cmd_ch.command)
			clnw_pkg::CMD_INIT: begin
				push_job.kind = clnw_pkg::JOB_INIT;
				push          = accept;
			end
			clnw_pkg::CMD_CLEAR: begin
				push_job.kind = clnw_pkg::JOB_CLEAR;
				push          = accept;
			end
			clnw_pkg::CMD_CHAR: begin
				push = accept && !full_disp;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (accept && is_char) begin
			if (full_disp) begin
				col_q  <= eff_col;
				line_q <= eff_line;
			end else if (col_wrap) begin
				col_q  <= '0;
				line_q <= eff_line + LINE_W'(1);
			end else begin
				col_q  <= eff_col + COL_W'(1);
				line_q <= eff_line;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/clnw_queue.sv
`default_nettype none
module clnw_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire clnw_pkg::job_t push_job,
	input  wire logic           pop,
	output clnw_pkg::job_t      head_job,
	output logic                head_valid,
	output logic                full
);
	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	clnw_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_pop;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_job   = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/clnw_back.sv
`default_nettype none
module clnw_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire clnw_pkg::cfg_t cfg,
	input  wire clnw_pkg::job_t head_job,
	input  wire logic           head_valid,
	output logic                pop,
	clnw_strobe_if.source       strobe_ch
);
	logic [3:0]  nib_q;
	logic        out_valid_q;
	logic        load;
	logic        final_nib;
	logic [2:0]  bidx;
	logic [7:0]  cur_byte;
	logic        cur_rs;
	logic        low_half;

	logic                      rs_q;
	logic [3:0]                nibble_q;
	logic [clnw_pkg::US_W-1:0] pulse_q;
	logic [clnw_pkg::US_W-1:0] wait_q;
	logic                      last_q;

	assign bidx      = nib_q[3:1];
	assign low_half  = nib_q[0];
	assign cur_byte  = clnw_pkg::job_byte(head_job, bidx);
	assign cur_rs    = clnw_pkg::job_rs(head_job, bidx);
	assign final_nib = nib_q == clnw_pkg::job_nibbles(head_job) - 4'd1;
	assign load      = head_valid && (!out_valid_q || strobe_ch.ready);
	assign pop       = load && final_nib;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				nib_q <= final_nib ? 4'd0 : nib_q + 4'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (strobe_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rs_q     <= cur_rs;
			nibble_q <= low_half ? cur_byte[3:0] : cur_byte[7:4];
			pulse_q  <= cfg.strobe_width;
			if (!low_half) begin
				wait_q <= '0;
			end else begin
				wait_q <= cur_rs ? cfg.data_settle : cfg.command_settle;
			end
			last_q   <= final_nib;
		end
	end

	assign strobe_ch.valid           = out_valid_q;
	assign strobe_ch.register_select = rs_q;
	assign strobe_ch.nibble          = nibble_q;
	assign strobe_ch.pulse_us        = pulse_q;
	assign strobe_ch.wait_after_us   = wait_q;
	assign strobe_ch.last            = last_q;
endmodule
`default_nettype wire

FILE: src/char_lcd_nibble_writer_core.sv
// Channel     Role   Transaction
// ---------   ----   ---------------------------------------------------------
// cmd_ch      sink   command (init / clear / char), char_code, first_of_message
// strobe_ch   source register_select, nibble, pulse_us, wait_after_us, last
// cfg_*       write  register index, 20-bit data, no read-back
//
// One nibble strobe leaves the output register per cycle while a job is
// queued and strobe_ch is ready; a job has 10 nibbles for init, 4 for clear,
// 2 or 4 for a char. The back sequencer has a single output register.
// cmd_ch takes a transaction whenever the two-entry job queue has room, also
// while a strobe stalls at the output. Reset clears the text position, the
// queue and the output, and loads the register defaults.
`default_nettype none
module char_lcd_nibble_writer_core #(
	parameter int unsigned CHARS_PER_LINE = 20,
	parameter int unsigned LINE_COUNT     = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	clnw_cmd_if.sink         cmd_ch,
	clnw_strobe_if.source    strobe_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_wdata
);
	clnw_pkg::cfg_t cfg_q;
	clnw_pkg::job_t push_job;
	clnw_pkg::job_t head_job;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           head_valid;

	// Configuration registers; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strobe_width   <= clnw_pkg::STROBE_WIDTH_RST;
			cfg_q.command_settle <= clnw_pkg::COMMAND_SETTLE_RST;
			cfg_q.data_settle    <= clnw_pkg::DATA_SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clnw_pkg::CFG_STROBE_WIDTH:   cfg_q.strobe_width   <= cfg_wdata;
				clnw_pkg::CFG_COMMAND_SETTLE: cfg_q.command_settle <= cfg_wdata;
				clnw_pkg::CFG_DATA_SETTLE:    cfg_q.data_settle    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Front: classifies each transaction and tracks the text position.
	clnw_front #(
		.CHARS_PER_LINE (CHARS_PER_LINE),
		.LINE_COUNT     (LINE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd_ch),
		.q_full   (q_full),
		.push_job (push_job),
		.push     (push)
	);

	// Short job queue decoupling intake from strobe generation.
	clnw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_job   (head_job),
		.head_valid (head_valid),
		.full       (q_full)
	);

	// Back: walks each job's bytes, high nibble then low nibble.
	clnw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_job   (head_job),
		.head_valid (head_valid),
		.pop        (pop),
		.strobe_ch  (strobe_ch)
	);
endmodule
`default_nettype wire
